// ----- rtl/wbss_pkg.sv -----
// ----------------------------------------------------------------------------
// wbss_pkg
// Types, sizes and helpers shared by the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

    localparam int MAX_SEGMENTS     = 64;
    localparam int MAX_ALTERNATIVES = 4;
    localparam int OFFSET_BITS      = 32;
    localparam int SEG_BITS         = $clog2(MAX_SEGMENTS);
    localparam int ALT_BITS         = $clog2(MAX_ALTERNATIVES);
    localparam int CNT_BITS         = SEG_BITS + 1;
    localparam int CFG_BITS         = 7;
    localparam int RES_OFFSET_BITS  = 32;

    typedef enum logic [1:0] {
        KIND_UNUSED    = 2'd0,
        KIND_EQUAL     = 2'd1,
        KIND_ANY       = 2'd2,
        KIND_NOT_EQUAL = 2'd3
    } t_alt_kind;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_SCAN = 1'b1
    } t_req_type;

    typedef struct packed {
        logic       req_type;
        logic [5:0] seg_index;
        logic [1:0] alt_index;
        logic [1:0] alt_kind;
        logic [7:0] alt_byte;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } t_scan_req;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } t_scan_res;

    typedef struct packed {
        t_alt_kind  kind;
        logic [7:0] value;
    } t_alt;

    typedef t_alt [MAX_ALTERNATIVES-1:0] t_alt_row;

    localparam t_alt ALT_EMPTY = '{kind: KIND_UNUSED, value: 8'd0};

    // a segment passes when any of its alternatives passes
    function automatic logic row_passes(t_alt_row row, logic [7:0] data);
        logic hit;
        hit = 1'b0;
        for (int a = 0; a < MAX_ALTERNATIVES; a++) begin
            unique case (row[a].kind)
                KIND_UNUSED:    hit = hit;
                KIND_EQUAL:     hit = hit | (row[a].value == data);
                KIND_ANY:       hit = 1'b1;
                KIND_NOT_EQUAL: hit = hit | (row[a].value != data);
            endcase
        end
        return hit;
    endfunction

endpackage

// ----- rtl/wbss_ram.sv -----
// ----------------------------------------------------------------------------
// wbss_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wbss_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/wildcard_byte_signature_scanner.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner
// Searches a byte stream for a signature of segments with wildcard options.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while the input is ready, load or scan;
// a scan beat's result is registered into the output register, or the
// skid register if the output is held. The rate is set by the comparison
// of a data byte against the current segment and, for the restart, against
// segment 0. Segment 0 lives in flip-flops; segments above it live in four
// RAMs, one for each alternative slot, read at the progress the next byte
// will use, so the row is ready when that byte arrives. Every table entry
// has a valid bit that reset clears, so no clearing pass is needed after
// reset. An output register and a skid register let input beats keep
// flowing while a result waits; input stalls only when both are full.
module wildcard_byte_signature_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wbss_pkg::t_scan_req                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wbss_pkg::t_scan_res                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [wbss_pkg::CFG_BITS-1:0]       i_cfg_data
);

    // configuration
    logic [wbss_pkg::CFG_BITS-1:0]    r_seg_count;
    logic [wbss_pkg::CNT_BITS-1:0]    cnt_eff;

    // pattern table
    logic [wbss_pkg::MAX_ALTERNATIVES-1:0] r_alt_valid [wbss_pkg::MAX_SEGMENTS];
    wbss_pkg::t_alt                   r_seg0 [wbss_pkg::MAX_ALTERNATIVES];
    logic [$bits(wbss_pkg::t_alt)-1:0] ram_rd [wbss_pkg::MAX_ALTERNATIVES];
    logic [wbss_pkg::MAX_ALTERNATIVES-1:0] ram_we;
    wbss_pkg::t_alt                   wr_alt;
    logic                             r_byp_hit;
    logic                             n_byp_hit;
    logic [wbss_pkg::ALT_BITS-1:0]    r_byp_alt;
    wbss_pkg::t_alt                   r_byp_value;
    wbss_pkg::t_alt_row               row0;
    wbss_pkg::t_alt_row               rowp;
    logic                             pass0;
    logic                             passp;

    // scan state
    logic [wbss_pkg::SEG_BITS-1:0]    r_prog;
    logic [wbss_pkg::SEG_BITS-1:0]    n_prog;
    logic [wbss_pkg::OFFSET_BITS-1:0] r_start;
    logic [wbss_pkg::OFFSET_BITS-1:0] n_start;
    logic [wbss_pkg::OFFSET_BITS-1:0] r_pos;
    logic [wbss_pkg::OFFSET_BITS-1:0] n_pos;
    logic                             r_done;
    logic                             n_done;
    logic                             pass;

    // handshake and results
    logic                             in_fire;
    logic                             load_fire;
    logic                             scan_fire;
    logic                             out_fire;
    logic                             res_valid;
    wbss_pkg::t_scan_res              res;
    logic                             r_out_valid;
    wbss_pkg::t_scan_res              r_out;
    logic                             r_skid_valid;
    wbss_pkg::t_scan_res              r_skid;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign load_fire = in_fire && (i_in_data.req_type == wbss_pkg::REQ_LOAD);
    assign scan_fire = in_fire && (i_in_data.req_type == wbss_pkg::REQ_SCAN);
    assign out_fire  = r_out_valid && i_out_ready;

    assign wr_alt = '{kind:  wbss_pkg::t_alt_kind'(i_in_data.alt_kind),
                      value: i_in_data.alt_byte};

    // the RAM row read now belongs to the row that was current at the write
    assign n_byp_hit = load_fire && (i_in_data.seg_index != '0)
                       && (i_in_data.seg_index == r_prog);

    always_comb begin
        if (r_seg_count == '0) begin
            cnt_eff = wbss_pkg::CNT_BITS'(1);
        end else if (int'(r_seg_count) > wbss_pkg::MAX_SEGMENTS) begin
            cnt_eff = wbss_pkg::CNT_BITS'(wbss_pkg::MAX_SEGMENTS);
        end else begin
            cnt_eff = wbss_pkg::CNT_BITS'(r_seg_count);
        end
    end

    generate
        for (genvar a = 0; a < wbss_pkg::MAX_ALTERNATIVES; a++) begin : g_alt
            assign ram_we[a] = load_fire && (i_in_data.seg_index != '0)
                               && (i_in_data.alt_index == wbss_pkg::ALT_BITS'(a));

            wbss_ram #(
                .WIDTH ($bits(wbss_pkg::t_alt)),
                .DEPTH (wbss_pkg::MAX_SEGMENTS)
            ) u_ram (
                .i_clk     (i_clk),
                .i_we      (ram_we[a]),
                .i_wr_addr (i_in_data.seg_index),
                .i_wr_data (wr_alt),
                .i_rd_addr (n_prog),
                .o_rd_data (ram_rd[a])
            );
        end
    endgenerate

    // rows for segment 0 and for the current segment
    always_comb begin
        for (int a = 0; a < wbss_pkg::MAX_ALTERNATIVES; a++) begin
            row0[a] = r_alt_valid[0][a] ? r_seg0[a] : wbss_pkg::ALT_EMPTY;
            if (!r_alt_valid[r_prog][a]) begin
                rowp[a] = wbss_pkg::ALT_EMPTY;
            end else if (r_byp_hit && (r_byp_alt == wbss_pkg::ALT_BITS'(a))) begin
                rowp[a] = r_byp_value;
            end else begin
                rowp[a] = wbss_pkg::t_alt'(ram_rd[a]);
            end
        end
        pass0 = wbss_pkg::row_passes(row0, i_in_data.data_byte);
        passp = wbss_pkg::row_passes(rowp, i_in_data.data_byte);
    end

    // scan step
    always_comb begin
        n_prog    = r_prog;
        n_start   = r_start;
        n_pos     = r_pos;
        n_done    = r_done;
        pass      = 1'b0;
        res_valid = 1'b0;
        res       = '{found: 1'b0, match_offset: '0};
        if (scan_fire) begin
            if (i_in_data.first) begin
                n_prog  = '0;
                n_start = '0;
                n_pos   = '0;
                n_done  = 1'b0;
            end
            if (!n_done) begin
                pass = (n_prog == '0) ? pass0 : passp;
                // mismatch past segment 0: retry the byte from the top
                if (!pass && (n_prog != '0)) begin
                    n_prog = '0;
                    pass   = pass0;
                end
                if (pass) begin
                    if (n_prog == '0) begin
                        n_start = n_pos;
                    end
                    if (({1'b0, n_prog} + wbss_pkg::CNT_BITS'(1)) >= cnt_eff) begin
                        n_done    = 1'b1;
                        n_prog    = '0;
                        res_valid = 1'b1;
                        res.found = 1'b1;
                        res.match_offset = wbss_pkg::RES_OFFSET_BITS'(n_start);
                    end else begin
                        n_prog = n_prog + 1'b1;
                    end
                end
                n_pos = n_pos + 1'b1;
                if (!res_valid && i_in_data.last) begin
                    n_done    = 1'b1;
                    n_prog    = '0;
                    res_valid = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count  <= wbss_pkg::CFG_BITS'(1);
            r_alt_valid  <= '{default: '0};
            r_byp_hit    <= 1'b0;
            r_prog       <= '0;
            r_start      <= '0;
            r_pos        <= '0;
            r_done       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seg_count <= i_cfg_data;
            end
            if (load_fire) begin
                r_alt_valid[i_in_data.seg_index][i_in_data.alt_index] <= 1'b1;
            end
            r_byp_hit <= n_byp_hit;
            r_prog    <= n_prog;
            r_start   <= n_start;
            r_pos     <= n_pos;
            r_done    <= n_done;
            if (!r_out_valid || out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load_fire && (i_in_data.seg_index == '0)) begin
            r_seg0[i_in_data.alt_index] <= wr_alt;
        end
        if (load_fire) begin
            r_byp_alt   <= i_in_data.alt_index;
            r_byp_value <= wr_alt;
        end
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

endmodule

// ----- rtl/wbss_checker.sv -----
// ----------------------------------------------------------------------------
// wbss_checker
// Port-level checks for the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
module wbss_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  wbss_pkg::t_scan_req i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  wbss_pkg::t_scan_res o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // input only backs up when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // not found always reports offset zero
    a_miss_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.match_offset == '0)
        else $error("not-found result with nonzero offset");

    // a fresh result comes from a scan beat taken the cycle before
    a_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready
                                     && i_in_data.req_type == wbss_pkg::REQ_SCAN))
        else $error("result without a preceding scan beat");

endmodule

bind wildcard_byte_signature_scanner wbss_checker u_wbss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
